/* rtl/core/matrix_chain_min_cost_core_macros.svh */
// Assertion macros used by the checker file of the chain cost core.
`ifndef MATRIX_CHAIN_MIN_COST_CORE_MACROS_SVH
`define MATRIX_CHAIN_MIN_COST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MCMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chain cost core: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define MCMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chain cost core: next-cycle check failed");

`endif

/* rtl/core/mcmc_pkg.sv */
// Types and constants of the matrix chain cost core.
package mcmc_pkg;

  localparam int DIM_W    = 16;
  localparam int COST_W   = 64;
  localparam int STATUS_W = 2;

  typedef logic [COST_W-1:0] cost_t;

  localparam cost_t COST_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_MATRICES = 2'd1,
    STAT_TOO_MANY    = 2'd2,
    STAT_SATURATED   = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DI    = 9'b000000010,
    ST_DJ    = 9'b000000100,
    ST_PIJ   = 9'b000001000,
    ST_KA    = 9'b000010000,
    ST_KB    = 9'b000100000,
    ST_KC    = 9'b001000000,
    ST_KD    = 9'b010000000,
    ST_WR    = 9'b100000000
  } state_t;

endpackage

/* rtl/core/mcmc_alu.sv */
// Shared arithmetic unit: one narrow multiplier and one saturating add with compare.
module mcmc_alu #(
  parameter int DIM_BITS = 16
) (
  input  logic [DIM_BITS-1:0]   mul_a,
  input  logic [DIM_BITS-1:0]   mul_b,
  input  mcmc_pkg::cost_t       add_a,
  input  mcmc_pkg::cost_t       add_b,
  input  mcmc_pkg::cost_t       cmp_ref,
  output logic [2*DIM_BITS-1:0] prod,
  output mcmc_pkg::cost_t       sum,
  output logic                  lt
);

  localparam int CostW = mcmc_pkg::COST_W;

  logic [CostW:0] wide_sum;

  assign prod     = mul_a * mul_b;
  assign wide_sum = {1'b0, add_a} + {1'b0, add_b};
  // clamp on carry out
  assign sum      = wide_sum[CostW] ? mcmc_pkg::COST_MAX : wide_sum[CostW-1:0];
  assign lt       = (sum < cmp_ref);

endmodule

/* rtl/core/matrix_chain_min_cost_core.sv */
// Top level of the matrix chain minimum cost core.
// Dimensions are loaded one word per cycle while busy is low (start high, last
// high on the final word). A chain with no matrix, one matrix, or too many
// dimensions returns its result on done in the cycle after the last word.
// Otherwise busy rises and a sequencer fills the cost table through one shared
// multiplier and one saturating adder: per table entry (i,j) it forms
// d[i]*d[j+1] in states DI, DJ and PIJ and writes the entry in WR, and passes
// through KA, KB, KC and KD for each split point k, which re-multiplies by
// d[k+1] in two halves and adds the two sub-costs. done pulses for one cycle
// as busy falls; the receiver cannot stall, so min_cost and status are valid
// only while done is high.
module matrix_chain_min_cost_core #(
  parameter int MAX_MATRICES = 32,
  parameter int DIM_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mcmc_pkg::DIM_W-1:0]      dim_value,
  input  logic                            last,
  output logic                            done,
  output logic [mcmc_pkg::COST_W-1:0]     min_cost,
  output logic [mcmc_pkg::STATUS_W-1:0]   status
);

  localparam int Slots  = MAX_MATRICES + 1;
  localparam int CW     = $clog2(MAX_MATRICES + 2);
  localparam int AW     = $clog2(MAX_MATRICES + 1);
  localparam int IW     = $clog2(MAX_MATRICES);
  localparam int CDepth = 2 ** (2 * IW);
  localparam int ExtW   = DIM_BITS + mcmc_pkg::DIM_W;
  localparam int CostW  = mcmc_pkg::COST_W;
  localparam int PadW   = CostW - 2 * DIM_BITS;
  localparam int HiPadW = CostW - 3 * DIM_BITS;

  localparam logic [CW-1:0] SlotsC = CW'(Slots);
  localparam logic [CW-1:0] TwoC   = CW'(2);
  localparam logic [IW-1:0] OneI   = IW'(1);

  mcmc_pkg::state_t state;

  logic [CW-1:0]         count;
  logic                  ovf;
  logic [IW-1:0]         nm1;
  logic [IW-1:0]         i;
  logic [IW-1:0]         j;
  logic [IW-1:0]         k;

  logic [DIM_BITS-1:0]   dim_mem [Slots];
  logic [AW-1:0]         dim_raddr;
  logic [DIM_BITS-1:0]   dim_rd;

  mcmc_pkg::cost_t       cost_mem [CDepth];
  logic [2*IW-1:0]       ca_addr;
  logic [2*IW-1:0]       cb_addr;
  mcmc_pkg::cost_t       ca_rd;
  mcmc_pkg::cost_t       cb_rd;

  logic [DIM_BITS-1:0]   di;
  logic [DIM_BITS-1:0]   dk;
  logic [2*DIM_BITS-1:0] pij;
  logic [2*DIM_BITS-1:0] plo;
  logic [2*DIM_BITS-1:0] phi;
  mcmc_pkg::cost_t       sum1;
  mcmc_pkg::cost_t       tsum;
  mcmc_pkg::cost_t       best;

  logic [ExtW-1:0]       dim_wide;
  logic [DIM_BITS-1:0]   din;
  logic                  accept;
  logic                  has_slot;
  logic [CW-1:0]         count_next;
  logic                  ovf_next;
  logic [CW-1:0]         nm1_wide;
  logic [IW-1:0]         k_inc;
  logic [IW-1:0]         span_inc;
  logic                  k_last;
  logic                  pair_last;

  logic [DIM_BITS-1:0]   mul_a;
  logic [DIM_BITS-1:0]   mul_b;
  mcmc_pkg::cost_t       add_a;
  mcmc_pkg::cost_t       add_b;
  logic [2*DIM_BITS-1:0] prod;
  mcmc_pkg::cost_t       sum;
  logic                  lt;

  assign busy       = (state != mcmc_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign dim_wide   = ExtW'(dim_value);
  assign din        = dim_wide[DIM_BITS-1:0];
  assign has_slot   = (count < SlotsC);
  assign count_next = has_slot ? count + CW'(1) : count;
  assign ovf_next   = ovf || !has_slot;
  assign nm1_wide   = count_next - TwoC;
  assign k_inc      = k + OneI;
  assign span_inc   = (j - i) + OneI;
  assign k_last     = (k_inc == j);
  assign pair_last  = (j == nm1);

  // Address and operand selection per sequencer step.
  always_comb begin
    dim_raddr = AW'(k) + AW'(1);
    ca_addr   = {i, k};
    cb_addr   = {k_inc, j};
    mul_a     = pij[DIM_BITS-1:0];
    mul_b     = dim_rd;
    add_a     = tsum;
    add_b     = {{HiPadW{1'b0}}, phi, {DIM_BITS{1'b0}}};
    unique case (state)
      mcmc_pkg::ST_DI: begin
        dim_raddr = AW'(i);
      end
      mcmc_pkg::ST_DJ: begin
        dim_raddr = AW'(j) + AW'(1);
      end
      mcmc_pkg::ST_PIJ: begin
        mul_a = di;
      end
      mcmc_pkg::ST_KB: begin
        // diagonal entries are zero and are never stored
        add_a = (k == i) ? '0 : ca_rd;
        add_b = k_last ? '0 : cb_rd;
      end
      mcmc_pkg::ST_KC: begin
        mul_a = pij[2*DIM_BITS-1:DIM_BITS];
        mul_b = dk;
        add_a = sum1;
        add_b = {{PadW{1'b0}}, plo};
      end
      default: begin
      end
    endcase
  end

  mcmc_alu #(
    .DIM_BITS (DIM_BITS)
  ) u_alu (
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .add_a   (add_a),
    .add_b   (add_b),
    .cmp_ref (best),
    .prod    (prod),
    .sum     (sum),
    .lt      (lt)
  );

  always_ff @(posedge clk) begin
    if (accept && has_slot) begin
      dim_mem[count[AW-1:0]] <= din;
    end
    dim_rd <= dim_mem[dim_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == mcmc_pkg::ST_WR) begin
      cost_mem[{i, j}] <= best;
    end
    ca_rd <= cost_mem[ca_addr];
    cb_rd <= cost_mem[cb_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      mcmc_pkg::ST_DJ: begin
        di <= dim_rd;
      end
      mcmc_pkg::ST_PIJ: begin
        pij  <= prod;
        best <= mcmc_pkg::COST_MAX;
      end
      mcmc_pkg::ST_KB: begin
        dk   <= dim_rd;
        plo  <= prod;
        sum1 <= sum;
      end
      mcmc_pkg::ST_KC: begin
        phi  <= prod;
        tsum <= sum;
      end
      mcmc_pkg::ST_KD: begin
        if (lt) begin
          best <= sum;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mcmc_pkg::ST_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      done     <= 1'b0;
      nm1      <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      min_cost <= '0;
      status   <= mcmc_pkg::STAT_OK;
    end else begin
      done <= 1'b0;
      unique case (state)
        mcmc_pkg::ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            ovf   <= ovf_next;
            if (last) begin
              count <= '0;
              ovf   <= 1'b0;
              priority if (ovf_next) begin
                done     <= 1'b1;
                min_cost <= '0;
                status   <= mcmc_pkg::STAT_TOO_MANY;
              end else if (count_next < TwoC) begin
                done     <= 1'b1;
                min_cost <= '0;
                status   <= mcmc_pkg::STAT_NO_MATRICES;
              end else if (count_next == TwoC) begin
                done     <= 1'b1;
                min_cost <= '0;
                status   <= mcmc_pkg::STAT_OK;
              end else begin
                nm1   <= nm1_wide[IW-1:0];
                i     <= '0;
                j     <= OneI;
                state <= mcmc_pkg::ST_DI;
              end
            end
          end
        end
        mcmc_pkg::ST_DI: begin
          state <= mcmc_pkg::ST_DJ;
        end
        mcmc_pkg::ST_DJ: begin
          state <= mcmc_pkg::ST_PIJ;
        end
        mcmc_pkg::ST_PIJ: begin
          k     <= i;
          state <= mcmc_pkg::ST_KA;
        end
        mcmc_pkg::ST_KA: begin
          state <= mcmc_pkg::ST_KB;
        end
        mcmc_pkg::ST_KB: begin
          state <= mcmc_pkg::ST_KC;
        end
        mcmc_pkg::ST_KC: begin
          state <= mcmc_pkg::ST_KD;
        end
        mcmc_pkg::ST_KD: begin
          if (k_last) begin
            state <= mcmc_pkg::ST_WR;
          end else begin
            k     <= k_inc;
            state <= mcmc_pkg::ST_KA;
          end
        end
        mcmc_pkg::ST_WR: begin
          priority if (pair_last && (i == '0)) begin
            // top corner written: whole chain done
            done     <= 1'b1;
            min_cost <= best;
            status   <= (best == mcmc_pkg::COST_MAX) ? mcmc_pkg::STAT_SATURATED
                                                     : mcmc_pkg::STAT_OK;
            state    <= mcmc_pkg::ST_IDLE;
          end else if (pair_last) begin
            // advance to the next diagonal
            i     <= '0;
            j     <= span_inc;
            state <= mcmc_pkg::ST_DI;
          end else begin
            i     <= i + OneI;
            j     <= j + OneI;
            state <= mcmc_pkg::ST_DI;
          end
        end
        default: begin
          state <= mcmc_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/mcmc_checker.sv */
// Port-level checker of the chain cost core and its bind.
`include "matrix_chain_min_cost_core_macros.svh"

module mcmc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          last,
  input logic                          done,
  input logic [mcmc_pkg::COST_W-1:0]   min_cost,
  input logic [mcmc_pkg::STATUS_W-1:0] status
);

  logic err_status;

  assign err_status = (status == mcmc_pkg::STAT_NO_MATRICES) ||
                      (status == mcmc_pkg::STAT_TOO_MANY);

  `MCMC_ASSERT_NXT(a_mid_word_no_result, start && !busy && !last, !done)
  `MCMC_ASSERT_IMP(a_fill_ends_with_result, $fell(busy), done)
  `MCMC_ASSERT_IMP(a_fill_follows_last, $rose(busy), $past(start && last))
  `MCMC_ASSERT_IMP(a_no_cost_on_error, done && err_status, min_cost == '0)
  `MCMC_ASSERT_IMP(a_saturation_flag, done, (status == mcmc_pkg::STAT_SATURATED) == (min_cost == '1))

endmodule

bind matrix_chain_min_cost_core mcmc_checker u_mcmc_checker (.*);
